// File: rtl/core/p2dsf_pkg.sv
// Shared constants, types and the divide-by-five digit helper for the scale factor unit.
`default_nettype none

package p2dsf_pkg;

    // Default widths of the mantissa and of the binary exponent.
    localparam int MANT_WIDTH_DEF = 64;
    localparam int EXP_WIDTH_DEF  = 12;

    // Width of the decimal exponent result.
    localparam int DEXP_WIDTH = 11;

    // Above this mantissa value a multiply by five would overflow, so the value is halved.
    localparam logic [63:0] MUL5_LIMIT_FULL = 64'h3333333333333333;

    // Fraction extension register and its thresholds.
    localparam int          FRAC_W         = 32;
    localparam int          FRAC_REM_SHIFT = 28;
    localparam logic [31:0] FRAC_ONE       = 32'h10000000;
    localparam logic [31:0] FRAC_TWO_HALF  = 32'h28000000;
    localparam logic [31:0] FRAC_MASK      = 32'h1FFFFFFF;
    localparam logic [31:0] FRAC_FIVE      = 32'h50000000;

    // Long division by five runs one byte per cycle.
    localparam int          DIGIT_W      = 8;
    localparam logic [11:0] RECIP5       = 12'd3277;
    localparam int          RECIP5_SHIFT = 14;

    typedef struct packed {
        logic [7:0] quot;
        logic [2:0] rem;
    } t_div5_digit;

    // One radix-256 step of division by five: the running remainder and the next byte
    // form a value below 1280, whose quotient comes from a reciprocal multiply.
    function automatic t_div5_digit div5_digit(input logic [2:0] rem_in,
                                               input logic [7:0] dig);
        logic [10:0]  val;
        logic [23:0]  prod;
        t_div5_digit  res;
        val      = {rem_in, dig};
        prod     = 24'(val) * 24'(RECIP5);
        res.quot = prod[RECIP5_SHIFT +: 8];
        res.rem  = 3'(val - 11'(res.quot) * 11'd5);
        return res;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/power_of_two_decimal_scale_factor_top.sv
// Decimal scale factor unit: normalized power-of-ten mantissa for a signed binary exponent.
//
// Usage: the input channel (i_in_valid / o_in_ready) carries one signed binary exponent per
// transaction. The output channel (o_out_valid / i_out_ready) returns one transaction with
// the rounded, normalized mantissa and the decimal exponent counted by the loop.
// The unit takes one exponent at a time and runs |e+1| steps on a shared datapath.
// A divide-by-five step is a long division that walks the mantissa and the 32-bit fraction
// one byte per cycle. After the last step the sequencer sees the exhausted step count,
// then rounds; a zero exponent goes straight to rounding.
// The sequencer returns to idle as the result is registered, ready for the next exponent.
// The result sits in an output register, so a new exponent is accepted while the previous
// result waits. If the receiver stalls, the next result is held in the rounding stage
// until it frees.
// Reset (synchronous, active low) returns the sequencer to idle and drops o_out_valid.
`default_nettype none

module power_of_two_decimal_scale_factor_top #(
    parameter int MANT_WIDTH = p2dsf_pkg::MANT_WIDTH_DEF,
    parameter int EXP_WIDTH  = p2dsf_pkg::EXP_WIDTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic signed [EXP_WIDTH-1:0]         i_bin_exponent,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [MANT_WIDTH-1:0]                    o_scale_mantissa,
    output logic signed [p2dsf_pkg::DEXP_WIDTH-1:0]  o_dec_exponent
);
    import p2dsf_pkg::*;

    // Division layout: the mantissa padded to whole bytes, then the fraction.
    localparam int NDIG_M = (MANT_WIDTH + DIGIT_W - 1) / DIGIT_W;
    localparam int PW     = NDIG_M * DIGIT_W;
    localparam int NDIG   = NDIG_M + FRAC_W / DIGIT_W;
    localparam int SW     = PW + FRAC_W;
    localparam int DIG_W  = $clog2(NDIG);

    localparam logic [MANT_WIDTH-1:0] MUL5_LIMIT = MUL5_LIMIT_FULL[MANT_WIDTH-1:0];
    localparam logic [MANT_WIDTH-1:0] MANT_TOP   = {1'b1, {(MANT_WIDTH-1){1'b0}}};

    // Sequencer states.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_STEP  = 2'd1;
    localparam logic [1:0] S_DIV   = 2'd2;
    localparam logic [1:0] S_ROUND = 2'd3;

    logic [1:0]                   r_state, n_state;
    logic [MANT_WIDTH-1:0]        r_m, n_m;
    logic [FRAC_W-1:0]            r_frac, n_frac;
    logic [DEXP_WIDTH-1:0]        r_dexp, n_dexp;
    logic [EXP_WIDTH-1:0]         r_steps, n_steps;
    logic                         r_neg, n_neg;
    logic [SW-1:0]                r_x, n_x;
    logic [2:0]                   r_rem, n_rem;
    logic [2:0]                   r_mrem, n_mrem;
    logic [DIG_W-1:0]             r_dig, n_dig;
    logic                         r_out_valid, n_out_valid;
    logic [MANT_WIDTH-1:0]        r_out_m, n_out_m;
    logic [DEXP_WIDTH-1:0]        r_out_dexp, n_out_dexp;

    logic signed [EXP_WIDTH:0]    w_ep;
    logic [EXP_WIDTH:0]           w_ep_abs;
    logic [FRAC_W-1:0]            w_frac5;
    logic [FRAC_W-1:0]            w_frac2;
    logic                         w_carry2;
    logic [2:0]                   w_rem_in;
    t_div5_digit                  w_digit;
    logic [FRAC_W-1:0]            w_round_thr;

    // Input decode: step count is |e+1| and its sign picks the direction.
    always_comb begin
        w_ep     = {i_bin_exponent[EXP_WIDTH-1], i_bin_exponent} + (EXP_WIDTH+1)'(1);
        w_ep_abs = w_ep[EXP_WIDTH] ? (EXP_WIDTH+1)'(-w_ep) : (EXP_WIDTH+1)'(w_ep);
    end

    // Shared datapath pieces: fraction times five, fraction doubling, one division digit.
    always_comb begin
        w_frac5     = {r_frac[FRAC_W-3:0], 2'b00} + r_frac;
        w_frac2     = {r_frac[FRAC_W-2:0], 1'b0};
        w_carry2    = (w_frac2 >= FRAC_FIVE);
        w_rem_in    = (r_dig == DIG_W'(NDIG_M)) ? 3'd0 : r_rem;
        w_digit     = div5_digit(w_rem_in, r_x[SW-1 -: DIGIT_W]);
        w_round_thr = r_neg ? FRAC_ONE : FRAC_TWO_HALF;
    end

    // Sequencer and next-state logic.
    always_comb begin
        n_state     = r_state;
        n_m         = r_m;
        n_frac      = r_frac;
        n_dexp      = r_dexp;
        n_steps     = r_steps;
        n_neg       = r_neg;
        n_x         = r_x;
        n_rem       = r_rem;
        n_mrem      = r_mrem;
        n_dig       = r_dig;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_m     = r_out_m;
        n_out_dexp  = r_out_dexp;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_frac  = '0;
                    n_dexp  = '0;
                    n_neg   = w_ep[EXP_WIDTH];
                    n_steps = w_ep_abs[EXP_WIDTH-1:0];
                    if (i_bin_exponent == '0) begin
                        n_m     = '0;
                        n_state = S_ROUND;
                    end else begin
                        n_m     = MANT_TOP;
                        n_state = S_STEP;
                    end
                end
            end
            S_STEP: begin
                if (r_steps == '0) begin
                    n_state = S_ROUND;
                end else if (r_neg) begin
                    n_steps = r_steps - EXP_WIDTH'(1);
                    if (r_m > MUL5_LIMIT) begin
                        // Halve, moving the low mantissa bit into the fraction.
                        n_frac = (r_frac >> 1) + (FRAC_W'(r_m[0]) << FRAC_REM_SHIFT);
                        n_m    = r_m >> 1;
                    end else begin
                        // Multiply by five, carrying the fraction overflow into the mantissa.
                        n_m    = {r_m[MANT_WIDTH-3:0], 2'b00} + r_m
                                 + MANT_WIDTH'(w_frac5[FRAC_W-1:29]);
                        n_frac = w_frac5 & FRAC_MASK;
                        n_dexp = r_dexp + DEXP_WIDTH'(1);
                    end
                end else if (r_m[MANT_WIDTH-1]) begin
                    // Start a long division by five over mantissa and fraction.
                    n_x     = {PW'(r_m), r_frac};
                    n_rem   = 3'd0;
                    n_dig   = '0;
                    n_steps = r_steps - EXP_WIDTH'(1);
                    n_dexp  = r_dexp - DEXP_WIDTH'(1);
                    n_state = S_DIV;
                end else begin
                    // Double, folding whole units of the fraction into the mantissa.
                    n_m     = {r_m[MANT_WIDTH-2:0], 1'b0} + MANT_WIDTH'(w_carry2);
                    n_frac  = w_carry2 ? (w_frac2 - FRAC_FIVE) : w_frac2;
                    n_steps = r_steps - EXP_WIDTH'(1);
                end
            end
            S_DIV: begin
                // One quotient byte per cycle; the remainder restarts at the fraction.
                n_x   = {r_x[SW-DIGIT_W-1:0], w_digit.quot};
                n_rem = w_digit.rem;
                n_dig = r_dig + DIG_W'(1);
                if (r_dig == DIG_W'(NDIG_M)) begin
                    n_mrem = r_rem;
                end
                if (r_dig == DIG_W'(NDIG - 1)) begin
                    n_m     = MANT_WIDTH'(n_x[SW-1:FRAC_W]);
                    n_frac  = n_x[FRAC_W-1:0] + (FRAC_W'(r_mrem) << FRAC_REM_SHIFT);
                    n_state = S_STEP;
                end
            end
            S_ROUND: begin
                // Round and hand the result over once the output register is free.
                if (!r_out_valid || i_out_ready) begin
                    n_out_m     = (r_frac >= w_round_thr) ? r_m + MANT_WIDTH'(1) : r_m;
                    n_out_dexp  = r_dexp;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_m        <= n_m;
        r_frac     <= n_frac;
        r_dexp     <= n_dexp;
        r_steps    <= n_steps;
        r_neg      <= n_neg;
        r_x        <= n_x;
        r_rem      <= n_rem;
        r_mrem     <= n_mrem;
        r_dig      <= n_dig;
        r_out_m    <= n_out_m;
        r_out_dexp <= n_out_dexp;
    end

    // Ports.
    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_scale_mantissa = r_out_m;
    assign o_dec_exponent   = r_out_dexp;

    // The division remainder is always a valid residue of five.
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < 3'd5))
        else $error("division remainder out of range");

    // The byte counter never runs past the last digit.
    a_dig_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dig <= DIG_W'(NDIG - 1)))
        else $error("division digit counter out of range");

    // On the negative side the fraction stays within 29 bits.
    a_frac_neg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP && r_neg) |-> ((r_frac & ~FRAC_MASK) == '0))
        else $error("fraction overflow on negative side");

    // On the positive side the fraction stays below one mantissa unit.
    a_frac_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP && !r_neg) |-> (r_frac < FRAC_FIVE))
        else $error("fraction overflow on positive side");

    // An accepted transaction closes the input side on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while busy");

endmodule

`default_nettype wire

// File: sim/power_of_two_decimal_scale_factor_top_test.sv
// Self-checking testbench for the decimal scale factor unit, with its own scale predictor.
module power_of_two_decimal_scale_factor_top_test;

    localparam int MANT_W = p2dsf_pkg::MANT_WIDTH_DEF;
    localparam int EXP_W  = p2dsf_pkg::EXP_WIDTH_DEF;
    localparam int DEXP_W = p2dsf_pkg::DEXP_WIDTH;

    localparam int RANDOM_ITEMS = 267;
    localparam int BURST_ITEMS  = 8;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 40;

    // One expected result: mantissa and decimal exponent.
    typedef struct packed {
        logic [MANT_W-1:0]        mant;
        logic signed [DEXP_W-1:0] dexp;
    } t_scale;

    // One row of directed stimulus; known rows carry a typed-in result.
    typedef struct packed {
        logic signed [EXP_W-1:0]  bexp;
        logic                     known;
        logic [MANT_W-1:0]        mant;
        logic signed [DEXP_W-1:0] dexp;
    } t_stim_row;

    localparam int N_ROWS = 23;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic signed [EXP_W-1:0]     i_bin_exponent;
    logic                        o_out_valid;
    logic                        i_out_ready;
    logic [MANT_W-1:0]           o_scale_mantissa;
    logic signed [DEXP_W-1:0]    o_dec_exponent;

    t_scale    scales_due[$];
    t_stim_row stim_table[N_ROWS];
    int        fail_count;
    bit        steady;
    bit        hold_off_req;

    power_of_two_decimal_scale_factor_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_bin_exponent   (i_bin_exponent),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_scale_mantissa (o_scale_mantissa),
        .o_dec_exponent   (o_dec_exponent)
    );

    // Scale factor for one binary exponent: halve or multiply by five below zero,
    // divide by five or double above it, then round on the fraction extension.
    function automatic t_scale scale_of_exponent(input logic signed [EXP_W-1:0] bexp);
        logic [MANT_W-1:0] top_bit;
        logic [MANT_W-1:0] mul5_limit;
        logic [MANT_W-1:0] m;
        logic [31:0]       frac;
        int                steps;
        int                dcount;
        t_scale            res;
        top_bit    = {1'b1, {(MANT_W-1){1'b0}}};
        mul5_limit = p2dsf_pkg::MUL5_LIMIT_FULL[MANT_W-1:0];
        m          = top_bit;
        frac       = '0;
        dcount     = 0;
        steps      = int'(bexp) + 1;
        if (bexp == 0) begin
            res.mant = '0;
            res.dexp = '0;
            return res;
        end
        if (steps < 0) begin
            while (steps < 0) begin
                if (m > mul5_limit) begin
                    frac = (frac >> 1) + (32'(m[0]) << 28);
                    m    = m >> 1;
                end else begin
                    m      = m * MANT_W'(5);
                    frac   = frac * 32'd5;
                    m      = m + MANT_W'(frac >> 29);
                    frac   = frac & p2dsf_pkg::FRAC_MASK;
                    dcount = dcount + 1;
                end
                steps = steps + 1;
            end
            if (frac >= p2dsf_pkg::FRAC_ONE) m = m + 1'b1;
        end else begin
            while (steps > 0) begin
                if (m[MANT_W-1]) begin
                    frac   = (frac / 32'd5) + (32'(m % MANT_W'(5)) << 28);
                    m      = m / MANT_W'(5);
                    dcount = dcount - 1;
                end else begin
                    m    = m << 1;
                    frac = frac << 1;
                    m    = m + MANT_W'(frac / p2dsf_pkg::FRAC_FIVE);
                    frac = frac % p2dsf_pkg::FRAC_FIVE;
                end
                steps = steps - 1;
            end
            if (frac >= p2dsf_pkg::FRAC_TWO_HALF) m = m + 1'b1;
        end
        res.mant = m;
        res.dexp = DEXP_W'(dcount);
        return res;
    endfunction

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Offers one exponent after the given gap and records its expected scale on acceptance.
    // Entered and left at a falling edge.
    task automatic offer_exponent(input logic signed [EXP_W-1:0] bexp, input logic known,
                                  input t_scale typed, input int gap);
        t_scale want;
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     = 1'b1;
        i_bin_exponent = bexp;
        do @(posedge i_clk); while (!o_in_ready);
        want = known ? typed : scale_of_exponent(bexp);
        scales_due.push_back(want);
        @(negedge i_clk);
    endtask

    // Stimulus: reset, directed table, a burst against a stalled receiver, then random items.
    initial begin
        int     k;
        int     rnd;
        int     sel;
        logic signed [EXP_W-1:0] bexp;
        t_scale typed;
        fail_count     = 0;
        steady         = 1'b0;
        hold_off_req   = 1'b0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_bin_exponent = '0;
        stim_table = '{
            '{12'sd0,     1'b1, 64'h0000000000000000, 11'sd0},
            '{-12'sd1,    1'b1, 64'h8000000000000000, 11'sd0},
            '{-12'sd2,    1'b1, 64'h4000000000000000, 11'sd0},
            '{12'sd1,     1'b0, 64'h0, 11'sd0},
            '{12'sd2,     1'b0, 64'h0, 11'sd0},
            '{-12'sd3,    1'b0, 64'h0, 11'sd0},
            '{12'sd3,     1'b0, 64'h0, 11'sd0},
            '{12'sd2047,  1'b0, 64'h0, 11'sd0},
            '{-12'sd2048, 1'b0, 64'h0, 11'sd0},
            '{-12'sd2047, 1'b0, 64'h0, 11'sd0},
            '{12'sd2046,  1'b0, 64'h0, 11'sd0},
            '{12'sd4,     1'b0, 64'h0, 11'sd0},
            '{-12'sd4,    1'b0, 64'h0, 11'sd0},
            '{12'sd5,     1'b0, 64'h0, 11'sd0},
            '{-12'sd5,    1'b0, 64'h0, 11'sd0},
            '{12'sd10,    1'b0, 64'h0, 11'sd0},
            '{-12'sd10,   1'b0, 64'h0, 11'sd0},
            '{12'sd63,    1'b0, 64'h0, 11'sd0},
            '{-12'sd64,   1'b0, 64'h0, 11'sd0},
            '{12'sd100,   1'b0, 64'h0, 11'sd0},
            '{-12'sd100,  1'b0, 64'h0, 11'sd0},
            '{12'sd1023,  1'b0, 64'h0, 11'sd0},
            '{-12'sd1024, 1'b0, 64'h0, 11'sd0}
        };
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed rows.
        for (k = 0; k < N_ROWS; k++) begin
            typed.mant = stim_table[k].mant;
            typed.dexp = stim_table[k].dexp;
            offer_exponent(stim_table[k].bexp, stim_table[k].known, typed,
                           $urandom_range(0, 5));
        end

        // Pause until every directed result has come back.
        i_in_valid = 1'b0;
        wait (scales_due.size() == 0);
        @(negedge i_clk);

        // Short exponents back to back while the receiver holds off, so the unit fills up.
        hold_off_req = 1'b1;
        for (k = 0; k < BURST_ITEMS; k++) begin
            bexp = EXP_W'(int'($urandom_range(0, 4)) - 2);
            offer_exponent(bexp, 1'b0, typed, 0);
        end

        // Random exponents: mostly short runs, some medium, a few across the full range.
        for (k = 0; k < RANDOM_ITEMS; k++) begin
            steady = (k >= 120 && k < 160);
            sel    = $urandom_range(0, 9);
            if (sel < 7) begin
                rnd  = $urandom_range(0, 80);
                bexp = EXP_W'(rnd - 40);
            end else if (sel < 9) begin
                rnd  = $urandom_range(0, 600);
                bexp = EXP_W'(rnd - 300);
            end else begin
                bexp = EXP_W'($urandom_range(0, (1 << EXP_W) - 1));
            end
            offer_exponent(bexp, 1'b0, typed, steady ? 0 : $urandom_range(0, 5));
        end
        steady     = 1'b0;
        i_in_valid = 1'b0;

        // Drain, then allow a few more cycles for any stray transaction.
        wait (scales_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("power_of_two_decimal_scale_factor_top_test: clean");
        end else begin
            $display("power_of_two_decimal_scale_factor_top_test: errors");
        end
        $finish;
    end

    // Receiver: random stall before each transaction, one long hold-off on request.
    initial begin
        int stall;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 5);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall        = HOLD_CYCLES;
            end
            if (stall > 0) begin
                i_out_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_out_ready = 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            @(negedge i_clk);
        end
    end

    // Compare each accepted result with the oldest expected scale.
    always @(posedge i_clk) begin
        t_scale want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (scales_due.size() == 0) begin
                $error("unexpected transaction: mantissa %h, dec_exponent %0d",
                       o_scale_mantissa, o_dec_exponent);
                fail_count++;
            end else begin
                want = scales_due.pop_front();
                if (o_scale_mantissa !== want.mant) begin
                    $error("scale_mantissa: expected %h, actual %h",
                           want.mant, o_scale_mantissa);
                    fail_count++;
                end
                if (o_dec_exponent !== want.dexp) begin
                    $error("dec_exponent: expected %0d, actual %0d",
                           want.dexp, o_dec_exponent);
                    fail_count++;
                end
            end
        end
    end

    // Run limit: several times the slowest correct run.
    initial begin
        #200_000_000;
        $display("power_of_two_decimal_scale_factor_top_test: errors");
        $finish;
    end

endmodule

// File: files.f
rtl/core/p2dsf_pkg.sv
rtl/core/power_of_two_decimal_scale_factor_top.sv
sim/power_of_two_decimal_scale_factor_top_test.sv
